// File: sv/sca_pkg.sv
// Shared types, constants and default parameters of the cycle averager.
`default_nettype none

package sca_pkg;

   // Field widths of the beats and of the register port.
   localparam int SAMPLE_W    = 16;
   localparam int OFFSET_W    = 12;
   localparam int CFG_LEN_W   = 13;
   localparam int CFG_PULSE_W = 7;
   localparam int CFG_FIRST_W = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   // Default sizes of the accumulator store and the pulse counter.
   localparam int DEF_MAX_CYCLE  = 4096;
   localparam int DEF_MAX_PULSES = 64;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_CYCLE_LENGTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_COUNT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_AVERAGED = 2'd2;

   // Register reset values.
   localparam logic [CFG_LEN_W-1:0]   RST_CYCLE_LENGTH   = 13'd1024;
   localparam logic [CFG_PULSE_W-1:0] RST_PULSE_COUNT    = 7'd8;
   localparam logic [CFG_FIRST_W-1:0] RST_FIRST_AVERAGED = 6'd0;

   typedef struct packed {
      logic                       restart;
      logic signed [SAMPLE_W-1:0] sample;
   } sca_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] average;
      logic [OFFSET_W-1:0]        offset;
      logic                       last;
      logic                       no_average;
   } sca_rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sca_div_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_ACCUM,
      ST_DIVIDE,
      ST_OUTPUT
   } sca_state_type;

endpackage

`default_nettype wire

// File: sv/sca_serial_divider.sv
// Bit-serial restoring divider: signed dividend by unsigned divisor, truncating toward zero.
`default_nettype none

module sca_serial_divider #(
   parameter int AW = 22,
   parameter int DW = 7
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic signed [AW-1:0]                 dividend,
   input  wire logic [DW-1:0]                        divisor,
   output sca_pkg::sca_div_status_type               status,
   output logic signed [sca_pkg::SAMPLE_W-1:0]       quotient
);

   localparam int CNTW = (AW > 1) ? $clog2(AW) : 1;

   logic [AW-1:0]   quot_ff, quot_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   div_ff, div_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic            neg_ff, neg_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;

   logic [DW:0]     rem_shift;
   logic [DW:0]     diff;
   logic [AW-1:0]   magnitude;
   logic [AW-1:0]   signed_quot;

   assign magnitude = dividend[AW-1] ? (~dividend + AW'(1)) : dividend;

   // One quotient bit per cycle: the dividend shifts out at the top while
   // quotient bits shift in at the bottom of the same register.
   assign rem_shift = {rem_ff, quot_ff[AW-1]};
   assign diff      = rem_shift - {1'b0, div_ff};

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      count_in = count_ff;
      neg_in   = neg_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quot_in  = magnitude;
         rem_in   = '0;
         div_in   = divisor;
         count_in = '0;
         neg_in   = dividend[AW-1];
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[AW-2:0], ~diff[DW]};
         rem_in   = diff[DW] ? rem_shift[DW-1:0] : diff[DW-1:0];
         count_in = count_ff + CNTW'(1);
         if (count_ff == CNTW'(AW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      count_ff <= count_in;
      neg_ff   <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign signed_quot = neg_ff ? (~quot_ff + AW'(1)) : quot_ff;
   assign quotient    = signed_quot[sca_pkg::SAMPLE_W-1:0];
   assign status      = '{busy: busy_ff, done: done_ff};

endmodule

`default_nettype wire

// File: sv/synchronous_cycle_averager_core.sv
// Top level of the synchronous cycle averager: counters, accumulator store and result register.
`default_nettype none

// Averages a pulsed recording cycle by cycle. Each accepted beat is one Q15 sample;
// from cycle first_averaged_pulse onward it is summed into a store entry chosen by
// its offset within the cycle, and during the last cycle every offset yields one
// result beat with the sum divided by the number of averaged cycles. A beat that
// produces no result passes through store read, accumulate and write in turn. A
// beat whose result needs a division also waits for the bit-serial divider, which
// retires one quotient bit per cycle (AW = 16 + log2(MAX_PULSES)); a beat whose
// result carries the no-average flag goes from accumulate straight to output.
// Either is held longer while a previous result still waits stalled in the result
// register. Beats after the last cycle, until a restart, are taken in idle and
// ignored. The result register lets the next sample in while a result waits. The
// store is not cleared after reset.
module synchronous_cycle_averager_core #(
   parameter int MAX_CYCLE  = sca_pkg::DEF_MAX_CYCLE,
   parameter int MAX_PULSES = sca_pkg::DEF_MAX_PULSES
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire sca_pkg::sca_req_type               req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output sca_pkg::sca_rsp_type                    rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [sca_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [sca_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int OW    = $clog2(MAX_CYCLE);
   localparam int LW    = (OW + 1 > sca_pkg::CFG_LEN_W) ? OW + 1 : sca_pkg::CFG_LEN_W;
   localparam int CW    = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;
   localparam int DW    = $clog2(MAX_PULSES + 1);
   localparam int PW    = (DW > sca_pkg::CFG_PULSE_W) ? DW : sca_pkg::CFG_PULSE_W;
   localparam int AW    = sca_pkg::SAMPLE_W + $clog2(MAX_PULSES);

   // Registers.
   logic [sca_pkg::CFG_LEN_W-1:0]   cfg_len_ff;
   logic [sca_pkg::CFG_PULSE_W-1:0] cfg_pulses_ff;
   logic [sca_pkg::CFG_FIRST_W-1:0] cfg_first_ff;

   sca_pkg::sca_state_type state_ff, state_in;

   logic [OW-1:0]    offset_ff, offset_in;
   logic [CW-1:0]    cycle_ff, cycle_in;
   logic             finished_ff, finished_in;

   // Per-sample working registers.
   logic signed [AW-1:0] sample_ff;
   logic [OW-1:0]        item_off_ff;
   logic                 contrib_ff, overwrite_ff, emit_ff, noavg_ff, last_ff;
   logic [DW-1:0]        divisor_ff;
   logic signed [AW-1:0] rdata_ff;
   logic signed [sca_pkg::SAMPLE_W-1:0] res_avg_ff, res_avg_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   sca_pkg::sca_rsp_type rsp_data_ff;

   logic signed [AW-1:0] mem [MAX_CYCLE];

   // Control.
   logic req_fire, slot_free;
   logic mem_we, div_start, res_load, out_load;

   logic            restart;
   logic            fin_eff;
   logic [OW-1:0]   o_eff;
   logic [CW-1:0]   c_eff;
   logic [LW-1:0]   len_raw, len_eff;
   logic [PW-1:0]   pc_raw, pc_eff, first_w, c_w;
   logic            final_offset, final_cycle, avg_en;

   logic signed [AW-1:0] acc_new;
   logic signed [AW-1:0] div_dividend;
   logic signed [sca_pkg::SAMPLE_W-1:0] div_quot;
   sca_pkg::sca_div_status_type div_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_len_ff    <= sca_pkg::RST_CYCLE_LENGTH;
         cfg_pulses_ff <= sca_pkg::RST_PULSE_COUNT;
         cfg_first_ff  <= sca_pkg::RST_FIRST_AVERAGED;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sca_pkg::CSR_CYCLE_LENGTH: begin
               cfg_len_ff <= csr_data[sca_pkg::CFG_LEN_W-1:0];
            end
            sca_pkg::CSR_PULSE_COUNT: begin
               cfg_pulses_ff <= csr_data[sca_pkg::CFG_PULSE_W-1:0];
            end
            sca_pkg::CSR_FIRST_AVERAGED: begin
               cfg_first_ff <= csr_data[sca_pkg::CFG_FIRST_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Effective settings and position of the incoming sample.
   assign req_fire  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign restart   = req_data.restart;
   assign fin_eff   = restart ? 1'b0 : finished_ff;
   assign o_eff     = restart ? '0 : offset_ff;
   assign c_eff     = restart ? '0 : cycle_ff;

   assign len_raw = LW'(cfg_len_ff);
   assign pc_raw  = PW'(cfg_pulses_ff);
   assign first_w = PW'(cfg_first_ff);
   assign c_w     = PW'(c_eff);

   always_comb begin
      if (len_raw == '0) begin
         len_eff = LW'(1);
      end else if (len_raw > LW'(MAX_CYCLE)) begin
         len_eff = LW'(MAX_CYCLE);
      end else begin
         len_eff = len_raw;
      end
      if (pc_raw == '0) begin
         pc_eff = PW'(1);
      end else if (pc_raw > PW'(MAX_PULSES)) begin
         pc_eff = PW'(MAX_PULSES);
      end else begin
         pc_eff = pc_raw;
      end
   end

   assign final_offset = (LW'(o_eff) + LW'(1)) >= len_eff;
   assign final_cycle  = (c_w + PW'(1)) >= pc_eff;
   assign avg_en       = first_w < pc_eff;

   // Position counters advance as soon as the sample is taken.
   always_comb begin
      offset_in   = offset_ff;
      cycle_in    = cycle_ff;
      finished_in = finished_ff;
      if (req_fire && !fin_eff) begin
         offset_in   = o_eff;
         cycle_in    = c_eff;
         finished_in = 1'b0;
         if (final_offset) begin
            offset_in = '0;
            if (final_cycle) begin
               finished_in = 1'b1;
            end else begin
               cycle_in = c_eff + CW'(1);
            end
         end else begin
            offset_in = o_eff + OW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sca_pkg::ST_IDLE;
         offset_ff   <= '0;
         cycle_ff    <= '0;
         finished_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         offset_ff   <= offset_in;
         cycle_ff    <= cycle_in;
         finished_ff <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff    <= AW'(req_data.sample);
         item_off_ff  <= o_eff;
         contrib_ff   <= avg_en && (c_w >= first_w);
         overwrite_ff <= c_w == first_w;
         emit_ff      <= final_cycle;
         noavg_ff     <= !avg_en;
         last_ff      <= final_offset;
         divisor_ff   <= DW'(pc_eff - first_w);
      end
      if (res_load) begin
         res_avg_ff <= res_avg_in;
      end
   end

   // Accumulator store, read every cycle at the current sample's offset.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[item_off_ff] <= acc_new;
      end
      rdata_ff <= mem[item_off_ff];
   end

   // The first averaged cycle overwrites the entry, so the store needs no clearing.
   assign acc_new      = overwrite_ff ? sample_ff : (rdata_ff + sample_ff);
   assign div_dividend = contrib_ff ? acc_new : '0;
   assign res_avg_in   = (state_ff == sca_pkg::ST_DIVIDE) ? div_quot : '0;

   sca_serial_divider #(
      .AW (AW),
      .DW (DW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (divisor_ff),
      .status   (div_status),
      .quotient (div_quot)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sca_pkg::ST_IDLE: begin
            if (req_fire && !fin_eff) begin
               state_in = sca_pkg::ST_READ;
            end
         end
         sca_pkg::ST_READ: begin
            state_in = sca_pkg::ST_ACCUM;
         end
         sca_pkg::ST_ACCUM: begin
            if (!emit_ff) begin
               state_in = sca_pkg::ST_IDLE;
            end else if (noavg_ff) begin
               state_in = sca_pkg::ST_OUTPUT;
            end else begin
               state_in = sca_pkg::ST_DIVIDE;
            end
         end
         sca_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = sca_pkg::ST_OUTPUT;
            end
         end
         sca_pkg::ST_OUTPUT: begin
            if (slot_free) begin
               state_in = sca_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sca_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      mem_we    = 1'b0;
      div_start = 1'b0;
      res_load  = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         sca_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         sca_pkg::ST_READ: begin
         end
         sca_pkg::ST_ACCUM: begin
            mem_we    = contrib_ff;
            div_start = emit_ff && !noavg_ff;
            res_load  = emit_ff && noavg_ff;
         end
         sca_pkg::ST_DIVIDE: begin
            res_load = div_status.done;
         end
         sca_pkg::ST_OUTPUT: begin
            out_load = slot_free;
         end
         default: begin
         end
      endcase
   end

   // Result register.
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         rsp_data_ff.average    <= res_avg_ff;
         rsp_data_ff.offset     <= sca_pkg::OFFSET_W'(item_off_ff);
         rsp_data_ff.last       <= last_ff;
         rsp_data_ff.no_average <= noavg_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // A measurement only finishes at the end of a cycle.
   a_finished_at_cycle_end: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> offset_ff == '0)
      else $error("finished with a nonzero offset");

   // The store is read only after a sample was taken in idle.
   a_read_follows_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == sca_pkg::ST_READ |-> $past(req_fire))
      else $error("store read without an accepted sample");

   // The divider never runs while the block is idle or reporting.
   a_divider_in_divide: assert property (@(posedge clock) disable iff (reset)
      (div_status.busy || div_status.done) |-> state_ff == sca_pkg::ST_DIVIDE)
      else $error("divider active outside the divide state");
`endif

endmodule

`default_nettype wire

// File: test/synchronous_cycle_averager_core_test.sv
// Self-checking testbench of the synchronous cycle averager core with random traffic and stalls.
module synchronous_cycle_averager_core_test;

   localparam int MAX_CYCLE     = sca_pkg::DEF_MAX_CYCLE;
   localparam int MAX_PULSES    = sca_pkg::DEF_MAX_PULSES;
   localparam int RANDOM_ITEMS  = 1850;
   localparam int QUIET_ITEMS   = 300;
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam logic [sca_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   sca_pkg::sca_req_type            req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   sca_pkg::sca_rsp_type            rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [sca_pkg::CSR_INDEX_W-1:0] csr_index = sca_pkg::CSR_CYCLE_LENGTH;
   logic [sca_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   synchronous_cycle_averager_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Register copies and averaging state as the block should hold them.
   logic [sca_pkg::CFG_LEN_W-1:0]   cfg_length = sca_pkg::RST_CYCLE_LENGTH;
   logic [sca_pkg::CFG_PULSE_W-1:0] cfg_pulses = sca_pkg::RST_PULSE_COUNT;
   logic [sca_pkg::CFG_FIRST_W-1:0] cfg_first  = sca_pkg::RST_FIRST_AVERAGED;
   int                     offset_sums [MAX_CYCLE];
   bit                     offset_seen [MAX_CYCLE];
   int                     offset_count = 0;
   int                     pulse_index = 0;
   bit                     measurement_done = 1'b0;

   sca_pkg::sca_req_type sample_queue[$];
   sca_pkg::sca_rsp_type expected_averages[$];
   int          mismatch_count = 0;
   int          queued_samples = 0;
   bit          sender_idling = 1'b1;
   bit          receiver_idling = 1'b1;
   int          send_gap = 0;
   int          recv_gap = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("synchronous_cycle_averager_core regression: fail");
      $finish;
   end

   function automatic int effective_length(input logic [sca_pkg::CFG_LEN_W-1:0] value);
      if (value == 0) return 1;
      if (value > MAX_CYCLE) return MAX_CYCLE;
      return int'(value);
   endfunction

   function automatic int effective_pulses(input logic [sca_pkg::CFG_PULSE_W-1:0] value);
      if (value == 0) return 1;
      if (value > MAX_PULSES) return MAX_PULSES;
      return int'(value);
   endfunction

   // Accumulates one accepted sample and queues the average it releases, if any.
   task automatic predict_average(input sca_pkg::sca_req_type beat);
      int          len, pulses, first, o, c, s, sum;
      bit          final_cycle, final_offset;
      sca_pkg::sca_rsp_type r;
      len    = effective_length(cfg_length);
      pulses = effective_pulses(cfg_pulses);
      first  = int'(cfg_first);
      s      = int'(beat.sample);
      if (beat.restart) begin
         offset_count     = 0;
         pulse_index      = 0;
         measurement_done = 1'b0;
      end
      if (measurement_done) return;
      o = offset_count % MAX_CYCLE;
      c = pulse_index;
      final_cycle  = (c + 1 >= pulses);
      final_offset = (o + 1 >= len);
      r = '0;
      r.offset = o[sca_pkg::OFFSET_W-1:0];
      r.last   = final_offset;
      if (first < pulses) begin
         if (c >= first) begin
            // The first averaged cycle overwrites whatever the entry held.
            if (c == first || !offset_seen[o]) offset_sums[o] = s;
            else offset_sums[o] += s;
            offset_seen[o] = 1'b1;
         end
         if (final_cycle) begin
            sum = (c >= first) ? offset_sums[o] : 0;
            r.average = sca_pkg::SAMPLE_W'(sum / (pulses - first));
            expected_averages.insert(expected_averages.size(), r);
         end
      end else if (final_cycle) begin
         r.no_average = 1'b1;
         expected_averages.insert(expected_averages.size(), r);
      end
      if (final_offset) begin
         offset_count = 0;
         if (final_cycle) measurement_done = 1'b1;
         else pulse_index = c + 1;
      end else begin
         offset_count = o + 1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) predict_average(req_data);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (sender_idling && $urandom_range(0, 7) == 0) begin
               send_gap  <= $urandom_range(0, 16);
               req_valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= sample_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      sca_pkg::sca_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_averages.size() == 0) begin
               $error("result beat at offset %0d with no average pending", rsp_data.offset);
               mismatch_count++;
            end else begin
               want = expected_averages.pop_front();
               if (rsp_data.average !== want.average) begin
                  $error("average: expected %0d, got %0d", want.average, rsp_data.average);
                  mismatch_count++;
               end
               if (rsp_data.offset !== want.offset) begin
                  $error("offset: expected %0d, got %0d", want.offset, rsp_data.offset);
                  mismatch_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_data.last);
                  mismatch_count++;
               end
               if (rsp_data.no_average !== want.no_average) begin
                  $error("no_average: expected %0b, got %0b", want.no_average,
                         rsp_data.no_average);
                  mismatch_count++;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap  <= recv_gap - 1;
            rsp_stall <= 1'b1;
         end else if (receiver_idling && $urandom_range(0, 11) == 0) begin
            recv_gap  <= $urandom_range(0, 16);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic signed [sca_pkg::SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         default: return sca_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic queue_sample(input bit restart,
                               input logic signed [sca_pkg::SAMPLE_W-1:0] value);
      sca_pkg::sca_req_type beat;
      beat.restart = restart;
      beat.sample  = value;
      sample_queue.insert(sample_queue.size(), beat);
      queued_samples++;
   endtask

   // Waits until every beat is in, every average is out and the block has gone quiet.
   // The check runs at the falling edge so that the driver's updates have settled.
   task automatic wait_until_settled();
      while (sample_queue.size() != 0 || req_valid || expected_averages.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [sca_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [sca_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         sca_pkg::CSR_CYCLE_LENGTH:   cfg_length = value[sca_pkg::CFG_LEN_W-1:0];
         sca_pkg::CSR_PULSE_COUNT:    cfg_pulses = value[sca_pkg::CFG_PULSE_W-1:0];
         sca_pkg::CSR_FIRST_AVERAGED: cfg_first  = value[sca_pkg::CFG_FIRST_W-1:0];
         default: ;
      endcase
   endtask

   // Writes all three registers; unused upper data bits are sometimes set.
   task automatic configure_averager(input logic [sca_pkg::CFG_LEN_W-1:0] len_value,
                                     input logic [sca_pkg::CFG_PULSE_W-1:0] pulse_value,
                                     input logic [sca_pkg::CFG_FIRST_W-1:0] first_value);
      logic [sca_pkg::CSR_DATA_W-1:0] upper;
      upper = ($urandom_range(0, 3) == 0) ? sca_pkg::CSR_DATA_W'($urandom) : '0;
      if ($urandom_range(0, 7) == 0)
         write_register(CSR_UNUSED, sca_pkg::CSR_DATA_W'($urandom));
      write_register(sca_pkg::CSR_CYCLE_LENGTH, len_value);
      write_register(sca_pkg::CSR_PULSE_COUNT,
                     {upper[sca_pkg::CSR_DATA_W-1:sca_pkg::CFG_PULSE_W], pulse_value});
      write_register(sca_pkg::CSR_FIRST_AVERAGED,
                     {upper[sca_pkg::CSR_DATA_W-1:sca_pkg::CFG_FIRST_W], first_value});
   endtask

   // One measurement of the given length, sometimes cut short or restarted midway.
   task automatic queue_measurement(input int count);
      int cut;
      if ($urandom_range(0, 9) == 0) count = $urandom_range(1, count);
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, count) : count;
      for (int i = 0; i < count; i++) queue_sample(i == 0 || i == cut, random_sample());
      if ($urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 3)) queue_sample(1'b0, random_sample());
   endtask

   initial begin : stimulus
      logic [sca_pkg::CFG_LEN_W-1:0]   len_value;
      logic [sca_pkg::CFG_PULSE_W-1:0] pulse_value;
      logic [sca_pkg::CFG_FIRST_W-1:0] first_value;
      int                     len, pulses, total, phase;

      while (reset) @(posedge clock);

      // A measurement also starts without restart right after reset. The second
      // offset checks that the division truncates toward zero.
      configure_averager(13'd2, 7'd2, 6'd0);
      queue_sample(1'b0, 16'sh7FFF);
      queue_sample(1'b0, 16'sh8000);
      queue_sample(1'b0, 16'sh7FFF);
      queue_sample(1'b0, -16'sd32767);
      queue_sample(1'b0, -16'sd1);
      wait_until_settled();

      // Out-of-range registers saturate; the start cycle lies beyond the last one.
      configure_averager(13'd0, 7'd0, 6'd63);
      queue_sample(1'b1, 16'sd0);
      queue_sample(1'b1, -16'sd1);
      queue_sample(1'b0, 16'sd1);
      wait_until_settled();

      // Cycle length shrinks below the offset counter in the middle of a cycle.
      configure_averager(13'd4, 7'd3, 6'd0);
      for (int i = 0; i < 7; i++) queue_sample(i == 0, random_sample());
      wait_until_settled();
      write_register(sca_pkg::CSR_CYCLE_LENGTH, 13'd2);
      repeat (3) queue_sample(1'b0, random_sample());
      wait_until_settled();

      // Pulse count shrinks below the cycle counter.
      configure_averager(13'd2, 7'd8, 6'd0);
      for (int i = 0; i < 6; i++) queue_sample(i == 0, random_sample());
      wait_until_settled();
      write_register(sca_pkg::CSR_PULSE_COUNT, 7'd2);
      repeat (3) queue_sample(1'b0, random_sample());
      wait_until_settled();

      queued_samples = 0;
      phase = 0;
      while (queued_samples < RANDOM_ITEMS) begin
         phase++;
         case ($urandom_range(0, 9))
            0:       len_value = '0;
            1:       len_value = sca_pkg::CFG_LEN_W'($urandom_range(13, 8191));
            default: len_value = sca_pkg::CFG_LEN_W'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 9))
            0:       pulse_value = '0;
            1:       pulse_value = 7'd127;
            2:       pulse_value = sca_pkg::CFG_PULSE_W'($urandom_range(7, 127));
            default: pulse_value = sca_pkg::CFG_PULSE_W'($urandom_range(1, 6));
         endcase
         if (phase == 1) begin
            len_value   = 13'd8191;
            pulse_value = 7'd0;
         end else if (phase == 2) begin
            len_value   = 13'd1;
            pulse_value = 7'd127;
         end
         pulses = effective_pulses(pulse_value);
         if ($urandom_range(0, 4) == 0)
            first_value = sca_pkg::CFG_FIRST_W'($urandom_range(0, 63));
         else first_value = sca_pkg::CFG_FIRST_W'($urandom_range(0, pulses - 1));
         if (phase == 1) first_value = '0;

         sender_idling   = (phase % 5 != 4) && (queued_samples < RANDOM_ITEMS - QUIET_ITEMS);
         receiver_idling = sender_idling;
         configure_averager(len_value, pulse_value, first_value);

         len   = effective_length(len_value);
         total = len * pulses;
         if (total <= 240) begin
            repeat ($urandom_range(1, 3)) begin
               queue_measurement(total);
               if ($urandom_range(0, 3) == 0) wait_until_settled();
            end
         end else begin
            // Long measurements are only begun; the next phase restarts anyway.
            queue_measurement($urandom_range(10, 150));
         end
         wait_until_settled();
      end

      wait_until_settled();
      if (mismatch_count == 0)
         $display("synchronous_cycle_averager_core regression: pass");
      else
         $display("synchronous_cycle_averager_core regression: fail");
      $finish;
   end

endmodule
